// ===== hw/rtl/ccrle_pkg.sv =====
`timescale 1ns / 1ps

package ccrle_pkg;

    // Fixed field widths
    localparam int CLASS_W    = 3;
    localparam int LEN_W      = 13;
    localparam int ROW_W      = 12;
    localparam int LW_W       = 13;
    localparam int CNT_W      = 3;
    localparam int CH_W       = 8;
    localparam int BOX_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CLUSTERS   = 6;
    localparam int DEF_MAX_LINE_WIDTH = 4096;
    localparam int DEF_RUN_INDEX_BITS = 20;

    localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 13'd640;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX0       = 3'd2;

    // Depth of the queue between classifier and run builder
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic               frame_start;
        logic [CLASS_W-1:0] cls;
    } pix_t;

endpackage

// ===== hw/rtl/ccrle_cfg.sv =====
`timescale 1ns / 1ps

module ccrle_cfg #(
    parameter int MAX_CLUSTERS = ccrle_pkg::DEF_MAX_CLUSTERS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ccrle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccrle_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [ccrle_pkg::CNT_W-1:0]          clusters_in_use,
    output logic [ccrle_pkg::LW_W-1:0]           line_width,
    output logic [ccrle_pkg::BOX_W-1:0]          boxes [MAX_CLUSTERS]
);

    logic [ccrle_pkg::CNT_W-1:0] clusters_reg;
    logic [ccrle_pkg::LW_W-1:0]  line_width_reg;
    logic [ccrle_pkg::BOX_W-1:0] box_reg [MAX_CLUSTERS];

    assign cfg_ready       = 1'b1;
    assign clusters_in_use = clusters_reg;
    assign line_width      = line_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg   <= '0;
            line_width_reg <= ccrle_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ccrle_pkg::REG_CLUSTERS)
                clusters_reg <= cfg_data[ccrle_pkg::CNT_W-1:0];
            if (cfg_index == ccrle_pkg::REG_LINE_WIDTH)
                line_width_reg <= cfg_data[ccrle_pkg::LW_W-1:0];
        end
    end

    // Boxes beyond MAX_CLUSTERS are never checked, so they are not stored
    for (genvar k = 0; k < MAX_CLUSTERS; k++)
    begin : g_box
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                box_reg[k] <= '0;
            else if (cfg_valid &&
                     cfg_index == ccrle_pkg::CFG_IDX_W'(int'(ccrle_pkg::REG_BOX0) + k))
                box_reg[k] <= cfg_data[ccrle_pkg::BOX_W-1:0];
        end
        assign boxes[k] = box_reg[k];
    end

endmodule

// ===== hw/rtl/ccrle_front.sv =====
`timescale 1ns / 1ps

module ccrle_front #(
    parameter int MAX_CLUSTERS = ccrle_pkg::DEF_MAX_CLUSTERS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            frame_start,
    input  logic [ccrle_pkg::CH_W-1:0]      chan_a,
    input  logic [ccrle_pkg::CH_W-1:0]      chan_b,
    input  logic [ccrle_pkg::CH_W-1:0]      chan_c,
    input  logic [ccrle_pkg::CNT_W-1:0]     clusters_in_use,
    input  logic [ccrle_pkg::BOX_W-1:0]     boxes [MAX_CLUSTERS],
    output logic                            push_valid,
    input  logic                            push_ready,
    output ccrle_pkg::pix_t                 push_item
);

    logic                  fr_valid_reg, fr_valid_next;
    ccrle_pkg::pix_t       fr_item_reg;
    logic [MAX_CLUSTERS-1:0] hit;
    logic [ccrle_pkg::CLASS_W-1:0] cls;
    logic                  accept;

    function automatic logic in_range(input logic [7:0] v, input logic [15:0] bounds);
        in_range = (v >= bounds[7:0]) && (v <= bounds[15:8]);
    endfunction

    always_comb
    begin
        for (int k = 0; k < MAX_CLUSTERS; k++)
        begin
            hit[k] = (ccrle_pkg::CNT_W'(k) < clusters_in_use)
                  && in_range(chan_a, boxes[k][15:0])
                  && in_range(chan_b, boxes[k][31:16])
                  && in_range(chan_c, boxes[k][47:32]);
        end
        // lowest-numbered matching cluster wins
        cls = '0;
        for (int k = MAX_CLUSTERS - 1; k >= 0; k--)
        begin
            if (hit[k])
                cls = ccrle_pkg::CLASS_W'(k + 1);
        end
    end

    assign in_ready      = !fr_valid_reg || push_ready;
    assign accept        = in_valid && in_ready;
    assign push_valid    = fr_valid_reg;
    assign push_item     = fr_item_reg;
    assign fr_valid_next = accept || (fr_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_item_reg.frame_start <= frame_start;
            fr_item_reg.cls         <= cls;
        end
    end

endmodule

// ===== hw/rtl/ccrle_queue.sv =====
`timescale 1ns / 1ps

module ccrle_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ccrle_pkg::pix_t    push_item,
    output logic               pop_valid,
    input  logic               pop,
    output ccrle_pkg::pix_t    pop_item
);

    localparam int DEPTH = ccrle_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccrle_pkg::pix_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/ccrle_back.sv =====
`timescale 1ns / 1ps

module ccrle_back #(
    parameter int MAX_LINE_WIDTH = ccrle_pkg::DEF_MAX_LINE_WIDTH,
    parameter int RUN_INDEX_BITS = ccrle_pkg::DEF_RUN_INDEX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ccrle_pkg::LW_W-1:0]        line_width,
    input  logic                              head_valid,
    input  ccrle_pkg::pix_t                   head_item,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ccrle_pkg::CLASS_W-1:0]     run_class,
    output logic [ccrle_pkg::LEN_W-1:0]       run_length,
    output logic [ccrle_pkg::ROW_W-1:0]       run_row,
    output logic [RUN_INDEX_BITS-1:0]         run_index,
    output logic                              run_overflow,
    output logic                              last_of_item
);

    localparam int LW_CAP_I = (MAX_LINE_WIDTH > 8191) ? 8191 : MAX_LINE_WIDTH;
    localparam logic [ccrle_pkg::LW_W-1:0] LW_CAP = ccrle_pkg::LW_W'(LW_CAP_I);
    localparam logic [RUN_INDEX_BITS-1:0]  IDX_TOP = '1;

    logic [ccrle_pkg::LEN_W-1:0]   col_reg;
    logic [ccrle_pkg::ROW_W-1:0]   row_reg;
    logic [ccrle_pkg::CLASS_W-1:0] oc_reg;
    logic [ccrle_pkg::LEN_W-1:0]   ol_reg;
    logic [RUN_INDEX_BITS-1:0]     rc_reg;
    logic                          ov_reg;
    logic                          phase_reg;   // first of two runs already sent
    logic                          out_valid_reg;

    logic [ccrle_pkg::CLASS_W-1:0] cls_reg;
    logic [ccrle_pkg::LEN_W-1:0]   len_reg;
    logic [ccrle_pkg::ROW_W-1:0]   row_out_reg;
    logic [RUN_INDEX_BITS-1:0]     idx_reg;
    logic                          ovf_reg;
    logic                          last_reg;

    logic [ccrle_pkg::LW_W-1:0]    width_eff;
    logic                          fs_eff;
    logic [ccrle_pkg::LEN_W-1:0]   col, col_inc, ol, new_len;
    logic [ccrle_pkg::ROW_W-1:0]   row;
    logic [ccrle_pkg::CLASS_W-1:0] oc, cls;
    logic [RUN_INDEX_BITS-1:0]     rc, rc_step;
    logic                          ov, ov_step;
    logic                          changed, eol, two, emit, fire;

    always_comb
    begin
        if (line_width == '0)
            width_eff = ccrle_pkg::LW_W'(1);
        else if (line_width > LW_CAP)
            width_eff = LW_CAP;
        else
            width_eff = line_width;

        // frame start was already applied during the first of two runs
        fs_eff  = head_item.frame_start && !phase_reg;
        cls     = head_item.cls;
        col     = fs_eff ? '0 : col_reg;
        row     = fs_eff ? '0 : row_reg;
        oc      = fs_eff ? '0 : oc_reg;
        ol      = fs_eff ? '0 : ol_reg;
        rc      = fs_eff ? RUN_INDEX_BITS'(1) : rc_reg;
        ov      = fs_eff ? 1'b0 : ov_reg;

        changed = (ol != '0) && (cls != oc);
        new_len = (ol == '0 || changed) ? ccrle_pkg::LEN_W'(1) : ol + 1'b1;
        col_inc = col + 1'b1;
        eol     = (col_inc >= width_eff);
        two     = changed && eol;
        emit    = changed || eol;

        rc_step = (rc == IDX_TOP) ? IDX_TOP : rc + 1'b1;
        ov_step = ov || (rc == IDX_TOP);

        fire    = head_valid && (!out_valid_reg || out_ready);
    end

    assign pop = fire && !two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            oc_reg        <= '0;
            ol_reg        <= '0;
            rc_reg        <= RUN_INDEX_BITS'(1);
            ov_reg        <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= emit;
            rc_reg        <= emit ? rc_step : rc;
            ov_reg        <= emit ? ov_step : ov;
            if (two)
            begin
                row_reg   <= row;
                col_reg   <= col;
                oc_reg    <= oc;
                ol_reg    <= '0;
                phase_reg <= 1'b1;
            end
            else if (eol)
            begin
                phase_reg <= 1'b0;
                ol_reg    <= '0;
                oc_reg    <= '0;
                col_reg   <= '0;
                row_reg   <= row + 1'b1;
            end
            else
            begin
                phase_reg <= 1'b0;
                row_reg   <= row;
                ol_reg    <= new_len;
                oc_reg    <= cls;
                col_reg   <= col_inc;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            row_out_reg <= row;
            idx_reg     <= rc;
            ovf_reg     <= ov;
            last_reg    <= !two;
            if (changed)
            begin
                cls_reg <= oc;
                len_reg <= ol;
            end
            else
            begin
                cls_reg <= cls;
                len_reg <= new_len;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign run_class    = cls_reg;
    assign run_length   = len_reg;
    assign run_row      = row_out_reg;
    assign run_index    = idx_reg;
    assign run_overflow = ovf_reg;
    assign last_of_item = last_reg;

endmodule

// ===== hw/rtl/color_class_run_length_encoder.sv =====
`timescale 1ns / 1ps

// Color-class run-length encoder. Takes one pixel per clock while in_ready is
// high; each pixel is classified against up to MAX_CLUSTERS min/max boxes by
// parallel comparators, queued, and merged into runs that leave on the out
// channel one run per clock while out_ready is high. A pixel that both ends a
// run and ends its row yields two runs and stays at the head of the queue
// until its second run is built. The first run of a pixel passes, in order,
// the classifier register (loaded on the accepting edge), the queue and the output register.
// cfg_ready is always high; write configuration only while idle.
module color_class_run_length_encoder #(
    parameter int MAX_CLUSTERS   = ccrle_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_LINE_WIDTH = ccrle_pkg::DEF_MAX_LINE_WIDTH,
    parameter int RUN_INDEX_BITS = ccrle_pkg::DEF_RUN_INDEX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccrle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccrle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              frame_start,
    input  logic [ccrle_pkg::CH_W-1:0]        chan_a,
    input  logic [ccrle_pkg::CH_W-1:0]        chan_b,
    input  logic [ccrle_pkg::CH_W-1:0]        chan_c,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ccrle_pkg::CLASS_W-1:0]     run_class,
    output logic [ccrle_pkg::LEN_W-1:0]       run_length,
    output logic [ccrle_pkg::ROW_W-1:0]       run_row,
    output logic [RUN_INDEX_BITS-1:0]         run_index,
    output logic                              run_overflow,
    output logic                              last_of_item
);

    logic [ccrle_pkg::CNT_W-1:0] clusters_in_use;
    logic [ccrle_pkg::LW_W-1:0]  line_width;
    logic [ccrle_pkg::BOX_W-1:0] boxes [MAX_CLUSTERS];

    logic              push_valid, push_ready;
    ccrle_pkg::pix_t   push_item;
    logic              head_valid, pop;
    ccrle_pkg::pix_t   head_item;

    ccrle_cfg #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .clusters_in_use (clusters_in_use),
        .line_width      (line_width),
        .boxes           (boxes)
    );

    ccrle_front #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .frame_start     (frame_start),
        .chan_a          (chan_a),
        .chan_b          (chan_b),
        .chan_c          (chan_c),
        .clusters_in_use (clusters_in_use),
        .boxes           (boxes),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    ccrle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (head_valid),
        .pop        (pop),
        .pop_item   (head_item)
    );

    ccrle_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .RUN_INDEX_BITS (RUN_INDEX_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_width   (line_width),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_class    (run_class),
        .run_length   (run_length),
        .run_row      (run_row),
        .run_index    (run_index),
        .run_overflow (run_overflow),
        .last_of_item (last_of_item)
    );

endmodule

// ===== hw/rtl/ccrle_checker.sv =====
`timescale 1ns / 1ps

module ccrle_checker #(
    parameter int RUN_INDEX_BITS = ccrle_pkg::DEF_RUN_INDEX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [ccrle_pkg::CLASS_W-1:0]     run_class,
    input  logic [ccrle_pkg::LEN_W-1:0]       run_length,
    input  logic [ccrle_pkg::ROW_W-1:0]       run_row,
    input  logic [RUN_INDEX_BITS-1:0]         run_index,
    input  logic                              run_overflow,
    input  logic                              last_of_item
);

    localparam logic [RUN_INDEX_BITS-1:0] IDX_TOP = '1;

    // stalled run holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(run_class) && $stable(run_length) && $stable(run_row)
            && $stable(run_index) && $stable(run_overflow) && $stable(last_of_item))
        else $error("run changed while stalled");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> run_length != '0)
        else $error("empty run emitted");

    a_ovf_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_overflow |-> run_index == IDX_TOP)
        else $error("overflow flagged below saturated index");

    // the second run of a pixel follows right away
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_item |=> out_valid && last_of_item)
        else $error("second run of a pixel missing");

endmodule

bind color_class_run_length_encoder ccrle_checker #(
    .RUN_INDEX_BITS (RUN_INDEX_BITS)
) u_ccrle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_class    (run_class),
    .run_length   (run_length),
    .run_row      (run_row),
    .run_index    (run_index),
    .run_overflow (run_overflow),
    .last_of_item (last_of_item)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ccrle_pkg::*;

    localparam int          IDX_W         = DEF_RUN_INDEX_BITS;
    localparam int          N_BOXES       = DEF_MAX_CLUSTERS;
    localparam int unsigned TOP_INDEX     = (1 << IDX_W) - 1;
    localparam int          IDLE_PCT      = 18;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [LEN_W-1:0]   len;
        logic [ROW_W-1:0]   row;
        logic [IDX_W-1:0]   idx;
        logic               ovf;
        logic               last;
    } run_t;

    // Predicts the runs of the encoder and checks the ones that leave it.
    class run_checker;
        logic [CNT_W-1:0]   clusters_used;
        logic [LW_W-1:0]    line_width;
        logic [BOX_W-1:0]   boxes [N_BOXES];
        int unsigned        column;
        logic [ROW_W-1:0]   row;
        logic [CLASS_W-1:0] open_cls;
        int unsigned        open_len;
        int unsigned        next_index;
        logic               saturated;
        run_t               expected_runs [$];
        int                 errors;

        function new();
            clusters_used = '0;
            line_width    = LINE_WIDTH_RESET;
            foreach (boxes[k]) boxes[k] = '0;
            column     = 0;
            row        = '0;
            open_cls   = '0;
            open_len   = 0;
            next_index = 1;
            saturated  = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_CLUSTERS)
                clusters_used = data[CNT_W-1:0];
            else if (index == REG_LINE_WIDTH)
                line_width = data[LW_W-1:0];
            else if (index >= REG_BOX0)
                boxes[int'(index - REG_BOX0)] = data[BOX_W-1:0];
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s", $time, msg);
        endfunction

        function string fmt_run(run_t r);
            return $sformatf("class %0d len %0d row %0d index %0d ovf %0b last %0b",
                             r.cls, r.len, r.row, r.idx, r.ovf, r.last);
        endfunction

        // first enabled box that holds all three channels wins
        function logic [CLASS_W-1:0] classify_pixel(logic [CH_W-1:0] a, b, c);
            int              used;
            logic [CH_W-1:0] ch [3];
            logic            hit;
            used  = (clusters_used > N_BOXES) ? N_BOXES : int'(clusters_used);
            ch[0] = a;
            ch[1] = b;
            ch[2] = c;
            for (int k = 0; k < used; k++)
            begin
                hit = 1'b1;
                for (int i = 0; i < 3; i++)
                    if (ch[i] < boxes[k][16*i +: 8] || ch[i] > boxes[k][16*i+8 +: 8])
                        hit = 1'b0;
                if (hit)
                    return CLASS_W'(k + 1);
            end
            return '0;
        endfunction

        function run_t close_run(logic [CLASS_W-1:0] cls, int unsigned len);
            run_t r;
            r.cls  = cls;
            r.len  = LEN_W'(len);
            r.row  = row;
            r.idx  = IDX_W'(next_index);
            r.ovf  = saturated;
            r.last = 1'b0;
            if (next_index >= TOP_INDEX)
            begin
                next_index = TOP_INDEX;
                saturated  = 1'b1;
            end
            else
                next_index++;
            return r;
        endfunction

        function void note_pixel(logic fs, logic [CH_W-1:0] a, b, c);
            int unsigned        width;
            logic [CLASS_W-1:0] cls;
            run_t               made [2];
            int                 n;
            n     = 0;
            width = 32'(line_width);
            if (width == 0)
                width = 1;
            if (width > DEF_MAX_LINE_WIDTH)
                width = DEF_MAX_LINE_WIDTH;
            // frame start drops any open run
            if (fs)
            begin
                column     = 0;
                row        = '0;
                open_cls   = '0;
                open_len   = 0;
                next_index = 1;
                saturated  = 1'b0;
            end
            cls = classify_pixel(a, b, c);
            if (open_len != 0 && cls != open_cls)
            begin
                made[n] = close_run(open_cls, open_len);
                n++;
                open_len = 0;
            end
            if (open_len == 0)
            begin
                open_cls = cls;
                open_len = 1;
            end
            else
                open_len++;
            column++;
            if (column >= width)
            begin
                made[n] = close_run(open_cls, open_len);
                n++;
                open_len = 0;
                open_cls = '0;
                column   = 0;
                row      = row + 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                made[i].last = (i == n - 1);
                expected_runs.push_back(made[i]);
            end
        endfunction

        function void check_run(run_t got);
            run_t want;
            if (expected_runs.size() == 0)
            begin
                report({"unexpected run: ", fmt_run(got)});
                return;
            end
            want = expected_runs.pop_front();
            if (got.cls !== want.cls || got.len !== want.len || got.row !== want.row ||
                got.idx !== want.idx || got.ovf !== want.ovf || got.last !== want.last)
                report({"run mismatch: expected ", fmt_run(want), " got ", fmt_run(got)});
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   frame_start  = 1'b0;
    logic [CH_W-1:0]        chan_a       = '0;
    logic [CH_W-1:0]        chan_b       = '0;
    logic [CH_W-1:0]        chan_c       = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [CLASS_W-1:0]     run_class;
    logic [LEN_W-1:0]       run_length;
    logic [ROW_W-1:0]       run_row;
    logic [IDX_W-1:0]       run_index;
    logic                   run_overflow;
    logic                   last_of_item;

    // no idling on either side while set
    logic                   calm         = 1'b0;

    run_checker runs = new();

    color_class_run_length_encoder dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                runs.note_pixel(frame_start, chan_a, chan_b, chan_c);
            if (out_valid && out_ready)
                runs.check_run(run_t'{run_class, run_length, run_row, run_index,
                                      run_overflow, last_of_item});
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        runs.write_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic fs, input logic [CH_W-1:0] a, b, c);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        frame_start <= fs;
        chan_a      <= a;
        chan_b      <= b;
        chan_c      <= c;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending, wait for all runs, then let the pipeline empty
    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < DRAIN_LIMIT && runs.pending() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BOX_W-1:0] random_box();
        logic [BOX_W-1:0] box;
        int               lo, hi, pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 48'hFF00_FF00_FF00;
        if (pick == 1)
            return BOX_W'({$urandom(), $urandom()});
        for (int i = 0; i < 3; i++)
        begin
            lo = $urandom_range(255);
            hi = lo + $urandom_range(90);
            if (hi > 255)
                hi = 255;
            // inverted bounds on one channel: box holds nothing
            if (pick == 2 && i == 1)
            begin
                lo = $urandom_range(255, 1);
                hi = $urandom_range(lo - 1);
            end
            box[16*i +: 8]   = lo[7:0];
            box[16*i+8 +: 8] = hi[7:0];
        end
        return box;
    endfunction

    function automatic logic [23:0] pixel_in(logic [BOX_W-1:0] box);
        logic [23:0] px;
        int          lo, hi;
        for (int i = 0; i < 3; i++)
        begin
            lo = int'(box[16*i +: 8]);
            hi = int'(box[16*i+8 +: 8]);
            px[8*i +: 8] = (lo <= hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom_range(255));
        end
        return px;
    endfunction

    // random configuration, then frames of runs drawn from the boxes
    task automatic random_phase(input int n_items, input bit pause_midway);
        int               width, eff, left, run_left, k;
        logic [23:0]      px;
        logic             fs;
        logic [BOX_W-1:0] boxes [N_BOXES];
        case ($urandom_range(9))
            0:       width = 0;
            1:       width = DEF_MAX_LINE_WIDTH;
            2:       width = (1 << LW_W) - 1;
            3:       width = $urandom_range((1 << LW_W) - 1);
            default: width = $urandom_range(24, 1);
        endcase
        eff = (width == 0) ? 1 : (width > DEF_MAX_LINE_WIDTH) ? DEF_MAX_LINE_WIDTH : width;
        write_reg(REG_CLUSTERS, CFG_DATA_W'($urandom_range(7)));
        write_reg(REG_LINE_WIDTH, CFG_DATA_W'(width));
        for (int b = 0; b < N_BOXES; b++)
        begin
            boxes[b] = random_box();
            write_reg(CFG_IDX_W'(REG_BOX0 + b), boxes[b]);
        end
        fs       = 1'b1;
        left     = eff;
        run_left = 0;
        k        = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(6, 1);
                k        = $urandom_range(N_BOXES);     // N_BOXES: unclassed noise
            end
            px = (k < N_BOXES && $urandom_range(9) != 0) ? pixel_in(boxes[k]) : 24'($urandom);
            // occasional broken frame restarting mid-row
            if ($urandom_range(99) == 0)
                fs = 1'b1;
            send_pixel(fs, px[7:0], px[15:8], px[23:16]);
            if (fs)
                left = eff;
            left--;
            run_left--;
            fs = 1'b0;
            if (left == 0)
            begin
                left = eff;
                fs   = ($urandom_range(4) == 0);
            end
            if (pause_midway && i == n_items / 2)
                go_idle();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // two boxes, four-pixel rows
        write_reg(REG_CLUSTERS, 2);
        write_reg(REG_LINE_WIDTH, 4);
        write_reg(REG_BOX0,                  48'h3C32_281E_140A);
        write_reg(CFG_IDX_W'(REG_BOX0 + 1), 48'hFF00_FF00_FF00);
        write_reg(CFG_IDX_W'(REG_BOX0 + 2), 48'h00FF_00FF_00FF);
        write_reg(CFG_IDX_W'(REG_BOX0 + 3), 48'h0000_0000_0000);
        write_reg(CFG_IDX_W'(REG_BOX0 + 4), 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_IDX_W'(REG_BOX0 + 5), 48'h8080_8080_8080);
        send_pixel(1'b1, 8'd15, 8'd35, 8'd55);
        send_pixel(1'b0, 8'd10, 8'd30, 8'd50);
        send_pixel(1'b0, 8'd20, 8'd40, 8'd60);
        // class change on the last pixel of the row
        send_pixel(1'b0, 8'd21, 8'd40, 8'd60);
        send_pixel(1'b0, 8'd0,  8'd0,  8'd0);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd15, 8'd35, 8'd61);
        send_pixel(1'b0, 8'd15, 8'd29, 8'd55);
        send_pixel(1'b0, 8'd15, 8'd35, 8'd55);
        send_pixel(1'b0, 8'd15, 8'd35, 8'd55);
        // frame start in mid-row drops the open run
        send_pixel(1'b1, 8'd128, 8'd128, 8'd128);
        send_pixel(1'b0, 8'd255, 8'd0, 8'd255);
        send_pixel(1'b0, 8'd20, 8'd40, 8'd60);
        send_pixel(1'b0, 8'd20, 8'd40, 8'd60);
        go_idle();

        // too many clusters, zero width: one run per pixel
        write_reg(REG_CLUSTERS, 7);
        write_reg(REG_LINE_WIDTH, 0);
        write_reg(CFG_IDX_W'(REG_BOX0 + 1), 48'h00FF_00FF_00FF);
        send_pixel(1'b0, 8'd0,   8'd0,   8'd0);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd128, 8'd128, 8'd128);
        send_pixel(1'b0, 8'd1,   8'd2,   8'd3);
        send_pixel(1'b0, 8'd15,  8'd35,  8'd55);
        go_idle();

        // no clusters, width above the maximum, then lowered in mid-row
        write_reg(REG_CLUSTERS, 0);
        write_reg(REG_LINE_WIDTH, 48'h1FFF);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd0,   8'd0,   8'd0);
        send_pixel(1'b0, 8'd7,   8'd7,   8'd7);
        go_idle();
        write_reg(REG_LINE_WIDTH, 2);
        send_pixel(1'b0, 8'd1, 8'd1, 8'd1);

        for (int p = 0; p < 8; p++)
        begin
            go_idle();
            calm <= (p == 2);
            random_phase(80, p == 4);
        end
        go_idle();

        if (runs.pending() != 0)
            runs.report($sformatf("%0d expected runs never arrived", runs.pending()));
        if (runs.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
